@@ sv/lcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsp_pkg
// Shared types and constants for the LRU cache with stream prefetch.
// ----------------------------------------------------------------------------
package lcsp_pkg;

   localparam int BLOCK_BITS  = 5;
   localparam int SET_BITS    = 6;
   localparam int SETS        = 64;
   localparam int WAYS        = 4;
   localparam int WAY_BITS    = 2;
   localparam int TAG_W       = 32 - BLOCK_BITS - SET_BITS;
   localparam int BLK_BITS    = 32 - BLOCK_BITS;
   localparam int STREAMS     = 8;
   localparam int STREAM_BITS = 3;
   localparam int MAX_DEPTH   = 16;
   localparam int DEPTH_W     = 5;
   localparam int CNT_W       = 4;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WB    = 2'd2;
   localparam logic [1:0] OP_PREF  = 2'd3;

   localparam logic CSR_STREAM_COUNT = 1'b0;
   localparam logic CSR_STREAM_DEPTH = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] address;
   } req_word_type;

   typedef struct packed {
      logic        cache_hit;
      logic        stream_hit;
      logic [1:0]  mem_op;
      logic [31:0] mem_addr;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [WAYS-1:0][TAG_W-1:0]    tag;
      logic [WAYS-1:0]               valid;
      logic [WAYS-1:0]               dirty;
      logic [WAYS-1:0][WAY_BITS-1:0] age;
   } row_type;

   // one classified access, expanded into words by the back end
   typedef struct packed {
      logic                cache_hit;
      logic                stream_hit;
      logic                wb_first;
      logic                wb_last;
      logic                demand;
      logic [DEPTH_W-1:0]  pf_cnt;
      logic [BLK_BITS-1:0] pf_blk;
      logic [BLK_BITS-1:0] dem_blk;
      logic [31:0]         wb_addr;
   } job_type;

endpackage

@@ sv/lcsp_front.sv @@
// ----------------------------------------------------------------------------
// lcsp_front
// Accepts accesses, looks up tags and stream windows, updates state, queues jobs.
// ----------------------------------------------------------------------------
module lcsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  lcsp_pkg::req_word_type req_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [4:0]            csr_wdata,
   input  logic                  job_full,
   output logic                  job_push,
   output lcsp_pkg::job_type     job_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   logic state_ff, state_in;
   logic [lcsp_pkg::CNT_W-1:0]   count_ff;
   logic [lcsp_pkg::DEPTH_W-1:0] depth_ff;
   lcsp_pkg::req_word_type req_ff;
   lcsp_pkg::row_type      rd_ff;
   lcsp_pkg::row_type      row_mem [lcsp_pkg::SETS];
   logic [lcsp_pkg::SETS-1:0] rowv_ff;

   logic [lcsp_pkg::STREAMS-1:0][lcsp_pkg::BLK_BITS-1:0]    start_ff, start_in;
   logic [lcsp_pkg::STREAMS-1:0]                            svalid_ff, svalid_in;
   logic [lcsp_pkg::STREAMS-1:0][lcsp_pkg::STREAM_BITS-1:0] rank_ff, rank_in;

   logic accept, fire;
   logic [lcsp_pkg::TAG_W-1:0] tag;
   logic [lcsp_pkg::SET_BITS-1:0] set_idx;
   logic [lcsp_pkg::BLK_BITS-1:0] blk, off, diff;
   lcsp_pkg::row_type row, new_row;
   logic hit, vfound, sh, vsfound;
   logic [lcsp_pkg::WAY_BITS-1:0] hit_way, vic_way, tway, told;
   logic [lcsp_pkg::CNT_W-1:0]   cnt;
   logic [lcsp_pkg::DEPTH_W-1:0] depth;
   logic [lcsp_pkg::STREAM_BITS-1:0] sb, sv, ts, trank;
   logic tstream;

   assign accept = push && (state_ff == ST_IDLE);
   assign full   = (state_ff != ST_IDLE);
   assign fire   = (state_ff == ST_LOOK) && !job_full;
   assign job_push = fire;

   assign blk     = req_ff.address[31:lcsp_pkg::BLOCK_BITS];
   assign set_idx = req_ff.address[lcsp_pkg::BLOCK_BITS +: lcsp_pkg::SET_BITS];
   assign tag     = req_ff.address[31 -: lcsp_pkg::TAG_W];
   assign cnt     = (count_ff > lcsp_pkg::CNT_W'(lcsp_pkg::STREAMS))
                    ? lcsp_pkg::CNT_W'(lcsp_pkg::STREAMS) : count_ff;
   assign depth   = (depth_ff == '0) ? lcsp_pkg::DEPTH_W'(1)
                  : ((depth_ff > lcsp_pkg::DEPTH_W'(lcsp_pkg::MAX_DEPTH))
                     ? lcsp_pkg::DEPTH_W'(lcsp_pkg::MAX_DEPTH) : depth_ff);

   always_comb begin
      // a row never written reads as the reset row
      if (rowv_ff[set_idx]) begin
         row = rd_ff;
      end else begin
         row = '0;
         for (int i = 0; i < lcsp_pkg::WAYS; i++) begin
            row.age[i] = lcsp_pkg::WAY_BITS'(i);
         end
      end

      hit = 1'b0;
      hit_way = '0;
      for (int i = lcsp_pkg::WAYS - 1; i >= 0; i--) begin
         if (row.valid[i] && row.tag[i] == tag) begin
            hit = 1'b1;
            hit_way = lcsp_pkg::WAY_BITS'(i);
         end
      end

      vfound = 1'b0;
      vic_way = '0;
      for (int i = lcsp_pkg::WAYS - 1; i >= 0; i--) begin
         if (!row.valid[i]) begin
            vfound = 1'b1;
            vic_way = lcsp_pkg::WAY_BITS'(i);
         end
      end
      if (!vfound) begin
         vic_way = '0;
         for (int i = lcsp_pkg::WAYS - 1; i >= 0; i--) begin
            if (row.age[i] == lcsp_pkg::WAY_BITS'(lcsp_pkg::WAYS - 1)) begin
               vic_way = lcsp_pkg::WAY_BITS'(i);
            end
         end
      end

      // stream lookup, most recent hitting buffer wins
      sh = 1'b0;
      sb = '0;
      for (int b = 0; b < lcsp_pkg::STREAMS; b++) begin
         diff = blk - start_ff[b];
         if ((lcsp_pkg::CNT_W'(b) < cnt) && svalid_ff[b]
             && (diff < lcsp_pkg::BLK_BITS'(depth))) begin
            if (!sh || rank_ff[b] < rank_ff[sb]) begin
               sb = lcsp_pkg::STREAM_BITS'(b);
            end
            sh = 1'b1;
         end
      end
      off = blk - start_ff[sb];

      vsfound = 1'b0;
      sv = '0;
      for (int b = 0; b < lcsp_pkg::STREAMS; b++) begin
         if (lcsp_pkg::CNT_W'(b) < cnt) begin
            if (!vsfound || rank_ff[b] > rank_ff[sv]) begin
               sv = lcsp_pkg::STREAM_BITS'(b);
            end
            vsfound = 1'b1;
         end
      end

      // row update
      new_row = row;
      tway = hit ? hit_way : vic_way;
      if (hit) begin
         new_row.dirty[hit_way] = row.dirty[hit_way] | req_ff.req_type;
      end else begin
         new_row.tag[vic_way]   = tag;
         new_row.valid[vic_way] = 1'b1;
         new_row.dirty[vic_way] = req_ff.req_type;
      end
      told = row.age[tway];
      for (int i = 0; i < lcsp_pkg::WAYS; i++) begin
         if (row.age[i] < told) new_row.age[i] = row.age[i] + 1'b1;
      end
      new_row.age[tway] = '0;

      // stream update
      start_in  = start_ff;
      svalid_in = svalid_ff;
      rank_in   = rank_ff;
      tstream   = 1'b0;
      ts        = sb;
      if (sh) begin
         tstream = 1'b1;
         start_in[sb] = start_ff[sb] + off + 1'b1;
      end else if (!hit && vsfound) begin
         tstream = 1'b1;
         ts = sv;
         svalid_in[sv] = 1'b1;
         start_in[sv] = blk + 1'b1;
      end
      trank = rank_ff[ts];
      if (tstream) begin
         for (int j = 0; j < lcsp_pkg::STREAMS; j++) begin
            if (rank_ff[j] < trank) rank_in[j] = rank_ff[j] + 1'b1;
         end
         rank_in[ts] = '0;
      end

      job_data.cache_hit  = hit;
      job_data.stream_hit = sh;
      job_data.wb_first   = !hit && sh && row.valid[vic_way] && row.dirty[vic_way];
      job_data.wb_last    = !hit && !sh && row.valid[vic_way] && row.dirty[vic_way];
      job_data.demand     = !hit && !sh;
      job_data.wb_addr    = {row.tag[vic_way], set_idx, lcsp_pkg::BLOCK_BITS'(0)};
      job_data.dem_blk    = blk;
      if (sh) begin
         job_data.pf_cnt = lcsp_pkg::DEPTH_W'(off) + 1'b1;
         job_data.pf_blk = start_ff[sb] + lcsp_pkg::BLK_BITS'(depth);
      end else if (!hit && vsfound) begin
         job_data.pf_cnt = depth;
         job_data.pf_blk = blk + 1'b1;
      end else begin
         job_data.pf_cnt = '0;
         job_data.pf_blk = blk + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept) state_in = ST_LOOK;
      else if (fire) state_in = ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= lcsp_pkg::CNT_W'(4);
         depth_ff  <= lcsp_pkg::DEPTH_W'(4);
         rowv_ff   <= '0;
         svalid_ff <= '0;
         for (int b = 0; b < lcsp_pkg::STREAMS; b++) begin
            start_ff[b] <= '0;
            rank_ff[b]  <= lcsp_pkg::STREAM_BITS'(b);
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               lcsp_pkg::CSR_STREAM_COUNT: count_ff <= csr_wdata[lcsp_pkg::CNT_W-1:0];
               lcsp_pkg::CSR_STREAM_DEPTH: depth_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            rowv_ff[set_idx] <= 1'b1;
            start_ff  <= start_in;
            svalid_ff <= svalid_in;
            rank_ff   <= rank_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
         rd_ff  <= row_mem[req_data.address[lcsp_pkg::BLOCK_BITS +: lcsp_pkg::SET_BITS]];
      end
      if (fire) row_mem[set_idx] <= new_row;
   end

endmodule

@@ sv/lcsp_jobq.sv @@
// ----------------------------------------------------------------------------
// lcsp_jobq
// Two-entry queue of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module lcsp_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   input  lcsp_pkg::job_type in_data,
   output logic              in_full,
   input  logic              out_pop,
   output lcsp_pkg::job_type out_data,
   output logic              out_empty
);

   lcsp_pkg::job_type q_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] n_ff, n_in;

   assign in_full   = (n_ff == 2'd2);
   assign out_empty = (n_ff == 2'd0);
   assign out_data  = q_ff[rp_ff];

   always_comb begin
      n_in = n_ff;
      if (in_push && !out_pop) n_in = n_ff + 1'b1;
      else if (!in_push && out_pop) n_in = n_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= '0;
      end else begin
         n_ff <= n_in;
         if (in_push) wp_ff <= ~wp_ff;
         if (out_pop) rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push) q_ff[wp_ff] <= in_data;
   end

endmodule

@@ sv/lcsp_back.sv @@
// ----------------------------------------------------------------------------
// lcsp_back
// Expands each job into result words in order and buffers them for the consumer.
// ----------------------------------------------------------------------------
module lcsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_empty,
   input  lcsp_pkg::job_type      job_data,
   output logic                   job_pop,
   output logic                   empty,
   input  logic                   pop,
   output lcsp_pkg::rsp_word_type rsp_data
);

   logic act_ff, ch_ff, sh_ff, wb1_ff, wb2_ff, dem_ff;
   logic [lcsp_pkg::DEPTH_W-1:0]  pf_left_ff;
   logic [lcsp_pkg::BLK_BITS-1:0] pf_blk_ff, dem_blk_ff;
   logic [31:0]                   wb_addr_ff;

   lcsp_pkg::rsp_word_type oq_ff [2];
   logic owp_ff, orp_ff;
   logic [1:0] on_ff, on_in;

   logic emit, wb1_n, wb2_n, dem_n, more;
   logic [lcsp_pkg::DEPTH_W-1:0] pf_n;
   lcsp_pkg::rsp_word_type word;

   assign job_pop = !act_ff && !job_empty;
   assign emit    = act_ff && (on_ff != 2'd2);
   assign empty   = (on_ff == 2'd0);
   assign rsp_data = oq_ff[orp_ff];

   always_comb begin
      wb1_n = wb1_ff;
      wb2_n = wb2_ff;
      dem_n = dem_ff;
      pf_n  = pf_left_ff;
      word.cache_hit  = ch_ff;
      word.stream_hit = sh_ff;
      word.mem_op     = lcsp_pkg::OP_NONE;
      word.mem_addr   = '0;
      // write-back ahead of prefetches on a stream-hit install
      if (wb1_ff) begin
         wb1_n = 1'b0;
         word.mem_op   = lcsp_pkg::OP_WB;
         word.mem_addr = wb_addr_ff;
      end else if (pf_left_ff != '0) begin
         pf_n = pf_left_ff - 1'b1;
         word.mem_op   = lcsp_pkg::OP_PREF;
         word.mem_addr = {pf_blk_ff, lcsp_pkg::BLOCK_BITS'(0)};
      end else if (dem_ff) begin
         dem_n = 1'b0;
         word.mem_op   = lcsp_pkg::OP_READ;
         word.mem_addr = {dem_blk_ff, lcsp_pkg::BLOCK_BITS'(0)};
      end else if (wb2_ff) begin
         wb2_n = 1'b0;
         word.mem_op   = lcsp_pkg::OP_WB;
         word.mem_addr = wb_addr_ff;
      end
      more = wb1_n || wb2_n || dem_n || (pf_n != '0);
      word.last = !more;

      on_in = on_ff;
      if (emit && !(pop && !empty)) on_in = on_ff + 1'b1;
      else if (!emit && pop && !empty) on_in = on_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         owp_ff <= 1'b0;
         orp_ff <= 1'b0;
         on_ff  <= '0;
      end else begin
         on_ff <= on_in;
         if (emit) owp_ff <= ~owp_ff;
         if (pop && !empty) orp_ff <= ~orp_ff;
         if (job_pop) act_ff <= 1'b1;
         else if (emit && !more) act_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         ch_ff      <= job_data.cache_hit;
         sh_ff      <= job_data.stream_hit;
         wb1_ff     <= job_data.wb_first;
         wb2_ff     <= job_data.wb_last;
         dem_ff     <= job_data.demand;
         pf_left_ff <= job_data.pf_cnt;
         pf_blk_ff  <= job_data.pf_blk;
         dem_blk_ff <= job_data.dem_blk;
         wb_addr_ff <= job_data.wb_addr;
      end else if (emit) begin
         wb1_ff     <= wb1_n;
         wb2_ff     <= wb2_n;
         dem_ff     <= dem_n;
         pf_left_ff <= pf_n;
         if (word.mem_op == lcsp_pkg::OP_PREF) pf_blk_ff <= pf_blk_ff + 1'b1;
      end
      if (emit) oq_ff[owp_ff] <= word;
   end

endmodule

@@ sv/lru_cache_with_stream_prefetch_top.sv @@
// ----------------------------------------------------------------------------
// lru_cache_with_stream_prefetch_top
// Write-back LRU cache model with stream-buffer prefetch, queue interfaces.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive req_data and raise push while full is low; the word
//   is taken on that edge. Each access is a read or write to a byte address.
//   Result side: while empty is low, rsp_data holds the oldest result word;
//   pop takes it. Each access yields one or more words (prefetches, demand
//   read, write-back in the order issued) with last set on the final one.
//   Config: csr_we with csr_index 0 (stream count) or 1 (stream depth);
//   write only while idle.
// Timing: the front end takes one access at a time (tag row read, then
//   classify and write back the row). The back end emits one word per cycle
//   while its output queue has room, and loads a job only after the last word
//   of the previous one. The first word passes the request and row registers,
//   the job queue, the back-end job registers and the output queue to rsp_data.
//   A two-entry job queue lets the front run ahead of the back end.
// Reset: synchronous; all lines and streams invalid, LRU ages restored,
//   stream count and depth 4. No clearing pass is needed.
// Stall: when pop stays low the output queue fills, the back end stops,
//   then the job queue fills and full stays high.
module lru_cache_with_stream_prefetch_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  lcsp_pkg::req_word_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output lcsp_pkg::rsp_word_type rsp_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [4:0]             csr_wdata
);

   logic              jq_push, jq_full, jq_pop, jq_empty;
   lcsp_pkg::job_type jq_in, jq_out;

   lcsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_full  (jq_full),
      .job_push  (jq_push),
      .job_data  (jq_in)
   );

   lcsp_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .in_push   (jq_push),
      .in_data   (jq_in),
      .in_full   (jq_full),
      .out_pop   (jq_pop),
      .out_data  (jq_out),
      .out_empty (jq_empty)
   );

   lcsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (jq_empty),
      .job_data  (jq_out),
      .job_pop   (jq_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
